@@ hdl/lrp_pkg.sv @@
package lrp_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int NUM_STATES      = 17;
  localparam int TABLE_ROWS      = 17;
  localparam int TERM_COLS       = 5;
  localparam int NONTERM_COLS    = 3;
  localparam int RULE_COUNT      = 8;
  localparam int RULE_OFFSET     = 10;

  localparam logic [7:0] SYM_STAR  = 8'h2A;
  localparam logic [7:0] SYM_EQ    = 8'h3D;
  localparam logic [7:0] SYM_ID    = 8'h69;
  localparam logic [7:0] SYM_END   = 8'h23;
  localparam logic [7:0] SYM_NUM   = 8'h6E;

  localparam logic [1:0] ST_SHIFTED  = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic [2:0] CA_NONE      = 3'd0;
  localparam logic [2:0] CA_NO_ACTION = 3'd1;
  localparam logic [2:0] CA_UNDERFLOW = 3'd2;
  localparam logic [2:0] CA_NO_GOTO   = 3'd3;
  localparam logic [2:0] CA_OVERFLOW  = 3'd4;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_SHIFT,
    ACT_REDUCE
  } act_kind_e;

  typedef struct packed {
    act_kind_e   kind;
    logic [4:0]  nxt;
    logic [1:0]  len;
    logic [1:0]  lhs;
  } act_t;

  typedef struct packed {
    logic        ok;
    logic [4:0]  nxt;
  } goto_t;

endpackage

@@ hdl/lr_parse_driver.sv @@
// lr parse driver for the fixed grammar T->S, S->L=R, S->R, L->*R, L->i, R->L, R->i, R->n
// input channel: symbol_i and start_req_i, taken when in_valid_i is high and in_stall_o
// is low; start_req_i clears the stack to state 0 before the symbol is handled
// output channel: one result item per input item, held in an output register until
// out_valid_o is high and out_stall_i is low
// each item runs through a small sequencer around one action/goto rom lookup:
// an action lookup, plus per reduction a stack ram read, then goto lookup and push,
// after which the action lookup is repeated; when the item is done its result goes
// to the result register and the sequencer returns to idle; only there is the next
// item taken
// in_stall_o is high while an item is being worked on; if the output register is
// still full when the result is ready, the sequencer waits until it drains
// the stack lives in a ram of STACK_DEPTH entries; entry 0 is never written, and a
// read of it is replaced by state 0, so no clearing pass is needed
// after reset the stack holds state 0, depth is 1 and the parse is not finished
module lr_parse_driver #(
  parameter int STACK_DEPTH = lrp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_i,
  input  logic       start_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [2:0] reject_cause_o,
  output logic [5:0] reductions_o,
  output logic [5:0] depth_o,
  output logic [4:0] top_state_o
);

  localparam int DW         = $clog2(STACK_DEPTH + 1);
  localparam int AW         = $clog2(STACK_DEPTH);
  localparam int REDUCE_CAP = 4 * STACK_DEPTH + 16;
  localparam int IW         = $clog2(REDUCE_CAP + 1);

  localparam logic [DW-1:0] DepthFull = DW'(STACK_DEPTH);
  localparam logic [DW-1:0] DepthOne  = DW'(1);
  localparam logic [IW-1:0] IterCap   = IW'(REDUCE_CAP);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACT  = 2'd1;
  localparam logic [1:0] S_GOTO = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [4:0]    top_q, top_d;
  logic          fin_q, fin_d;
  logic [7:0]    sym_q, sym_d;
  logic [DW-1:0] pop_q, pop_d;
  logic [1:0]    lhs_q, lhs_d;
  logic [5:0]    reds_q, reds_d;
  logic [IW-1:0] iter_q, iter_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q, status_d;
  logic [2:0]    cause_q, cause_d;
  logic [5:0]    reds_out_q, reds_out_d;
  logic [5:0]    depth_out_q, depth_out_d;
  logic [4:0]    top_out_q, top_out_d;

  lrp_pkg::act_t  act;
  lrp_pkg::goto_t gto;
  logic [4:0]     rdata;
  logic [4:0]     below;
  logic [AW-1:0]  raddr;
  logic           ram_we;
  logic [DW-1:0]  ram_wdepth;
  logic [4:0]     ram_wdata;
  logic           out_free;
  logic           done;
  logic [1:0]     res_st;
  logic [2:0]     res_ca;
  logic [DW-1:0]  new_depth;
  logic [4:0]     new_top;
  logic           push;

  lrp_rom u_rom (
    .sym_i   (sym_q),
    .top_i   (top_q),
    .below_i (below),
    .lhs_i   (lhs_q),
    .act_o   (act),
    .goto_o  (gto)
  );

  lrp_ram #(
    .WIDTH (5),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wdepth[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign below    = (pop_q == DepthOne) ? 5'd0 : rdata;
  assign raddr    = (state_q == S_GOTO) ? AW'(pop_q - DepthOne)
                                        : AW'(depth_q - DW'(act.len) - DepthOne);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    top_d       = top_q;
    fin_d       = fin_q;
    sym_d       = sym_q;
    pop_d       = pop_q;
    lhs_d       = lhs_q;
    reds_d      = reds_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    cause_d     = cause_q;
    reds_out_d  = reds_out_q;
    depth_out_d = depth_out_q;
    top_out_d   = top_out_q;
    ram_we      = 1'b0;
    ram_wdepth  = depth_q;
    ram_wdata   = act.nxt;
    done        = 1'b0;
    res_st      = lrp_pkg::ST_SHIFTED;
    res_ca      = lrp_pkg::CA_NONE;
    new_depth   = depth_q;
    new_top     = top_q;
    push        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d   = symbol_i;
          reds_d  = '0;
          iter_d  = '0;
          state_d = S_ACT;
          if (start_req_i) begin
            depth_d = DepthOne;
            top_d   = 5'd0;
            fin_d   = 1'b0;
          end
        end
      end
      S_ACT: begin
        if (fin_q) begin
          done   = 1'b1;
          res_st = lrp_pkg::ST_IGNORED;
        end else if (iter_q >= IterCap) begin
          done   = 1'b1;
          res_st = lrp_pkg::ST_REJECTED;
          res_ca = lrp_pkg::CA_NO_ACTION;
        end else begin
          case (act.kind)
            lrp_pkg::ACT_ACCEPT: begin
              done   = 1'b1;
              res_st = lrp_pkg::ST_ACCEPTED;
            end
            lrp_pkg::ACT_SHIFT: begin
              done = 1'b1;
              if (depth_q >= DepthFull) begin
                res_st = lrp_pkg::ST_REJECTED;
                res_ca = lrp_pkg::CA_OVERFLOW;
              end else begin
                push       = 1'b1;
                ram_wdepth = depth_q;
                ram_wdata  = act.nxt;
                new_depth  = depth_q + DepthOne;
                new_top    = act.nxt;
              end
            end
            lrp_pkg::ACT_REDUCE: begin
              if (depth_q <= DW'(act.len)) begin
                done   = 1'b1;
                res_st = lrp_pkg::ST_REJECTED;
                res_ca = lrp_pkg::CA_UNDERFLOW;
              end else begin
                pop_d   = depth_q - DW'(act.len);
                lhs_d   = act.lhs;
                state_d = S_GOTO;
              end
            end
            default: begin
              done   = 1'b1;
              res_st = lrp_pkg::ST_REJECTED;
              res_ca = lrp_pkg::CA_NO_ACTION;
            end
          endcase
        end
      end
      S_GOTO: begin
        new_depth = pop_q;
        new_top   = below;
        if (!gto.ok) begin
          done   = 1'b1;
          res_st = lrp_pkg::ST_REJECTED;
          res_ca = lrp_pkg::CA_NO_GOTO;
        end else if (pop_q >= DepthFull) begin
          done   = 1'b1;
          res_st = lrp_pkg::ST_REJECTED;
          res_ca = lrp_pkg::CA_OVERFLOW;
        end else begin
          ram_we     = 1'b1;
          ram_wdepth = pop_q;
          ram_wdata  = gto.nxt;
          depth_d    = pop_q + DepthOne;
          top_d      = gto.nxt;
          reds_d     = (reds_q == 6'd63) ? reds_q : reds_q + 6'd1;
          iter_d     = iter_q + IW'(1);
          state_d    = S_ACT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done && out_free) begin
      depth_d     = new_depth;
      top_d       = new_top;
      ram_we      = push;
      fin_d       = (res_st == lrp_pkg::ST_ACCEPTED) || (res_st == lrp_pkg::ST_REJECTED)
                    || fin_q;
      out_valid_d = 1'b1;
      status_d    = res_st;
      cause_d     = res_ca;
      reds_out_d  = reds_q;
      depth_out_d = 6'(new_depth);
      top_out_d   = new_top;
      state_d     = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= DepthOne;
      top_q       <= 5'd0;
      fin_q       <= 1'b0;
      reds_q      <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      top_q       <= top_d;
      fin_q       <= fin_d;
      reds_q      <= reds_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    pop_q       <= pop_d;
    lhs_q       <= lhs_d;
    status_q    <= status_d;
    cause_q     <= cause_d;
    reds_out_q  <= reds_out_d;
    depth_out_q <= depth_out_d;
    top_out_q   <= top_out_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign reject_cause_o = cause_q;
  assign reductions_o   = reds_out_q;
  assign depth_o        = depth_out_q;
  assign top_state_o    = top_out_q;

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q != '0) && (depth_q <= DepthFull))
    else $error("stack depth out of range");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_wdepth != '0) && (ram_wdepth < DepthFull))
    else $error("stack write outside the stack");

  a_cause_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((status_q == lrp_pkg::ST_REJECTED) == (cause_q != lrp_pkg::CA_NONE)))
    else $error("reject cause does not match status");

  a_ignored_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == lrp_pkg::ST_IGNORED) |-> (reds_out_q == 6'd0))
    else $error("ignored item reports reductions");

  a_goto_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GOTO) |-> ($past(state_q) == S_ACT || $past(state_q) == S_GOTO))
    else $error("goto step without a preceding action lookup");

endmodule

@@ hdl/lrp_ram.sv @@
module lrp_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = lrp_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lrp_rom.sv @@
module lrp_rom (
  input  logic [7:0]    sym_i,
  input  logic [4:0]    top_i,
  input  logic [4:0]    below_i,
  input  logic [1:0]    lhs_i,
  output lrp_pkg::act_t  act_o,
  output lrp_pkg::goto_t goto_o
);

  localparam logic signed [7:0] E = -8'sd1;

  localparam logic signed [7:0] ACT_ROM [lrp_pkg::TABLE_ROWS][lrp_pkg::TERM_COLS] = '{
    '{8'sd1, E, 8'sd5, E, 8'sd6},
    '{E, E, 8'sd9, E, 8'sd10},
    '{E, 8'sd11, E, -8'sd15, E},
    '{E, E, E, -8'sd12, E},
    '{E, E, E, 8'sd0, E},
    '{E, E, E, -8'sd14, E},
    '{E, E, E, -8'sd17, E},
    '{E, -8'sd15, E, -8'sd15, E},
    '{E, -8'sd13, E, -8'sd13, E},
    '{E, -8'sd14, E, -8'sd14, E},
    '{E, -8'sd17, E, -8'sd17, E},
    '{8'sd12, E, 8'sd15, E, 8'sd6},
    '{8'sd12, E, 8'sd15, E, 8'sd6},
    '{E, E, E, -8'sd15, E},
    '{E, E, E, -8'sd11, E},
    '{E, E, E, -8'sd16, E},
    '{E, E, E, -8'sd13, E}
  };

  localparam logic signed [7:0] GOTO_ROM [lrp_pkg::TABLE_ROWS][lrp_pkg::NONTERM_COLS] = '{
    '{8'sd4, 8'sd2, 8'sd3},
    '{E, 8'sd7, 8'sd8},
    '{E, E, E}, '{E, E, E}, '{E, E, E}, '{E, E, E}, '{E, E, E},
    '{E, E, E}, '{E, E, E}, '{E, E, E}, '{E, E, E},
    '{E, 8'sd13, 8'sd14},
    '{E, 8'sd13, 8'sd16},
    '{E, E, E}, '{E, E, E}, '{E, E, E}, '{E, E, E}
  };

  localparam logic [1:0] RULE_LEN [lrp_pkg::RULE_COUNT] = '{
    2'd1, 2'd3, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1
  };
  localparam logic [1:0] RULE_LHS [lrp_pkg::RULE_COUNT] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3
  };

  localparam logic [5:0] RowLimit = 6'(lrp_pkg::NUM_STATES < lrp_pkg::TABLE_ROWS ?
                                        lrp_pkg::NUM_STATES : lrp_pkg::TABLE_ROWS);

  logic              col_ok;
  logic [2:0]        col;
  logic              row_ok;
  logic [4:0]        row_idx;
  logic signed [7:0] act_val;
  logic signed [7:0] rule_sel;
  logic [2:0]        rule_idx;
  logic              below_ok;
  logic [4:0]        below_idx;
  logic [1:0]        goto_col;
  logic signed [7:0] goto_val;

  always_comb begin
    col_ok = 1'b1;
    col    = 3'd0;
    case (sym_i)
      lrp_pkg::SYM_STAR: col = 3'd0;
      lrp_pkg::SYM_EQ:   col = 3'd1;
      lrp_pkg::SYM_ID:   col = 3'd2;
      lrp_pkg::SYM_END:  col = 3'd3;
      lrp_pkg::SYM_NUM:  col = 3'd4;
      default:           col_ok = 1'b0;
    endcase
  end

  assign row_ok   = {1'b0, top_i} < RowLimit;
  assign row_idx  = row_ok ? top_i : 5'd0;
  assign act_val  = ACT_ROM[row_idx][col];
  assign rule_sel = -act_val - 8'(lrp_pkg::RULE_OFFSET);
  assign rule_idx = rule_sel[2:0];

  always_comb begin
    act_o      = '0;
    act_o.kind = lrp_pkg::ACT_NONE;
    act_o.nxt  = act_val[4:0];
    act_o.len  = RULE_LEN[rule_idx];
    act_o.lhs  = RULE_LHS[rule_idx];
    if (col_ok && row_ok && act_val != E) begin
      if (act_val == 8'sd0) begin
        act_o.kind = lrp_pkg::ACT_ACCEPT;
      end else if (act_val > 8'sd0) begin
        act_o.kind = lrp_pkg::ACT_SHIFT;
      end else if (rule_sel >= 8'sd0 && rule_sel < 8'(lrp_pkg::RULE_COUNT)) begin
        act_o.kind = lrp_pkg::ACT_REDUCE;
      end
    end
  end

  assign below_ok   = {1'b0, below_i} < RowLimit;
  assign below_idx  = below_ok ? below_i : 5'd0;
  assign goto_col   = (lhs_i == 2'd0) ? 2'd0 : lhs_i - 2'd1;
  assign goto_val   = GOTO_ROM[below_idx][goto_col];
  assign goto_o.ok  = (lhs_i != 2'd0) && below_ok && (goto_val >= 8'sd0);
  assign goto_o.nxt = goto_val[4:0];

endmodule

@@ sim/tb.sv @@
module tb;

  localparam int STACK_LIMIT = lrp_pkg::STACK_DEPTH_DEF;
  localparam int REDUCE_CAP  = 4 * STACK_LIMIT + 16;

  localparam int COL_NONE = -1;
  localparam int COL_STAR = 0;
  localparam int COL_EQ   = 1;
  localparam int COL_ID   = 2;
  localparam int COL_END  = 3;
  localparam int COL_NUM  = 4;

  localparam int LHS_T = 0;
  localparam int LHS_S = 1;
  localparam int LHS_L = 2;
  localparam int LHS_R = 3;

  localparam int ACT_EMPTY = -1;
  localparam int ACT_ACC   = 0;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] cause;
    logic [5:0] reductions;
    logic [5:0] depth;
    logic [4:0] top;
  } parse_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] symbol_i    = 8'h00;
  logic       start_req_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  logic [2:0] reject_cause_o;
  logic [5:0] reductions_o;
  logic [5:0] depth_o;
  logic [4:0] top_state_o;

  lr_parse_driver #(
    .STACK_DEPTH(STACK_LIMIT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .symbol_i      (symbol_i),
    .start_req_i   (start_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .reject_cause_o(reject_cause_o),
    .reductions_o  (reductions_o),
    .depth_o       (depth_o),
    .top_state_o   (top_state_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // action columns * = i # n, goto columns S L R
  int act_tab [lrp_pkg::TABLE_ROWS][lrp_pkg::TERM_COLS] = '{
    '{1, -1, 5, -1, 6}, '{-1, -1, 9, -1, 10}, '{-1, 11, -1, -15, -1},
    '{-1, -1, -1, -12, -1}, '{-1, -1, -1, 0, -1}, '{-1, -1, -1, -14, -1},
    '{-1, -1, -1, -17, -1}, '{-1, -15, -1, -15, -1}, '{-1, -13, -1, -13, -1},
    '{-1, -14, -1, -14, -1}, '{-1, -17, -1, -17, -1}, '{12, -1, 15, -1, 6},
    '{12, -1, 15, -1, 6}, '{-1, -1, -1, -15, -1}, '{-1, -1, -1, -11, -1},
    '{-1, -1, -1, -16, -1}, '{-1, -1, -1, -13, -1}
  };
  int goto_tab [lrp_pkg::TABLE_ROWS][lrp_pkg::NONTERM_COLS] = '{
    '{4, 2, 3}, '{-1, 7, 8}, '{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1},
    '{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1},
    '{-1, -1, -1}, '{-1, -1, -1}, '{-1, 13, 14}, '{-1, 13, 16},
    '{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}
  };
  int rule_len [lrp_pkg::RULE_COUNT] = '{1, 3, 1, 2, 1, 1, 1, 1};
  int rule_lhs [lrp_pkg::RULE_COUNT] = '{
    LHS_T, LHS_S, LHS_S, LHS_L, LHS_L, LHS_R, LHS_R, LHS_R
  };

  logic [4:0] state_stk [STACK_LIMIT];
  int         stk_depth;
  bit         parse_done;

  parse_result_t step_results_q [$];
  logic [7:0]    sentence_q [$];
  parse_result_t seen_r;
  parse_result_t want_r;

  bit calm = 1'b0;
  int out_hold = 0;
  int errors = 0;
  int fed_count = 0;
  int parsed_count = 0;
  int accept_count = 0;
  int reject_count = 0;
  int overflow_count = 0;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic void clear_parser();
    foreach (state_stk[i]) state_stk[i] = 5'd0;
    stk_depth  = 1;
    parse_done = 1'b0;
  endfunction

  function automatic int stack_top();
    if (stk_depth == 0 || stk_depth > STACK_LIMIT) return 0;
    return int'(state_stk[stk_depth - 1]);
  endfunction

  function automatic int term_column(logic [7:0] sym);
    case (sym)
      lrp_pkg::SYM_STAR: return COL_STAR;
      lrp_pkg::SYM_EQ:   return COL_EQ;
      lrp_pkg::SYM_ID:   return COL_ID;
      lrp_pkg::SYM_END:  return COL_END;
      lrp_pkg::SYM_NUM:  return COL_NUM;
      default:           return COL_NONE;
    endcase
  endfunction

  function automatic parse_result_t parse_symbol(logic [7:0] sym, logic start);
    parse_result_t r;
    int col, top, act, idx, below, nxt, iter;
    bit stop;
    r    = '0;
    iter = 0;
    stop = 1'b0;
    if (start) clear_parser();
    if (parse_done) begin
      r.status = lrp_pkg::ST_IGNORED;
    end else begin
      col      = term_column(sym);
      r.status = lrp_pkg::ST_SHIFTED;
      while (!stop) begin
        top = stack_top();
        stop = 1'b1;
        if (col == COL_NONE || top >= lrp_pkg::NUM_STATES || top >= lrp_pkg::TABLE_ROWS ||
            iter >= REDUCE_CAP) begin
          r.cause = lrp_pkg::CA_NO_ACTION;
        end else begin
          act = act_tab[top][col];
          if (act == ACT_ACC) begin
            r.status = lrp_pkg::ST_ACCEPTED;
          end else if (act == ACT_EMPTY) begin
            r.cause = lrp_pkg::CA_NO_ACTION;
          end else if (act > 0) begin
            if (stk_depth >= STACK_LIMIT) begin
              r.cause = lrp_pkg::CA_OVERFLOW;
            end else begin
              state_stk[stk_depth] = act[4:0];
              stk_depth++;
            end
          end else begin
            idx = -act - lrp_pkg::RULE_OFFSET;
            if (idx < 0 || idx >= lrp_pkg::RULE_COUNT) begin
              r.cause = lrp_pkg::CA_NO_ACTION;
            end else if (stk_depth <= rule_len[idx]) begin
              r.cause = lrp_pkg::CA_UNDERFLOW;
            end else begin
              stk_depth -= rule_len[idx];
              below = stack_top();
              if (rule_lhs[idx] == LHS_T || below >= lrp_pkg::NUM_STATES ||
                  below >= lrp_pkg::TABLE_ROWS) begin
                r.cause = lrp_pkg::CA_NO_GOTO;
              end else begin
                nxt = goto_tab[below][rule_lhs[idx] - LHS_S];
                if (nxt < 0) begin
                  r.cause = lrp_pkg::CA_NO_GOTO;
                end else if (stk_depth >= STACK_LIMIT) begin
                  r.cause = lrp_pkg::CA_OVERFLOW;
                end else begin
                  state_stk[stk_depth] = nxt[4:0];
                  stk_depth++;
                  if (r.reductions < 6'd63) r.reductions++;
                  iter++;
                  stop = 1'b0;
                end
              end
            end
          end
        end
      end
      if (r.cause != lrp_pkg::CA_NONE) r.status = lrp_pkg::ST_REJECTED;
      if (r.status == lrp_pkg::ST_ACCEPTED || r.status == lrp_pkg::ST_REJECTED)
        parse_done = 1'b1;
    end
    r.depth = stk_depth[5:0];
    r.top   = 5'(stack_top());
    return r;
  endfunction

  task automatic feed_symbol(input logic [7:0] sym, input logic start);
    int gap;
    parse_result_t want;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    symbol_i    <= sym;
    start_req_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    want = parse_symbol(sym, start);
    step_results_q.insert(step_results_q.size(), want);
    fed_count++;
    if (want.status != lrp_pkg::ST_IGNORED) parsed_count++;
    if (want.status == lrp_pkg::ST_ACCEPTED) accept_count++;
    if (want.status == lrp_pkg::ST_REJECTED) reject_count++;
    if (want.cause == lrp_pkg::CA_OVERFLOW) overflow_count++;
  endtask

  task automatic feed_sentence();
    foreach (sentence_q[i]) feed_symbol(sentence_q[i], i == 0);
  endtask

  function automatic logic [7:0] pick_terminal();
    case ($urandom_range(0, 4))
      0:       return lrp_pkg::SYM_STAR;
      1:       return lrp_pkg::SYM_EQ;
      2:       return lrp_pkg::SYM_ID;
      3:       return lrp_pkg::SYM_END;
      default: return lrp_pkg::SYM_NUM;
    endcase
  endfunction

  function automatic void append_sym(logic [7:0] sym);
    sentence_q.insert(sentence_q.size(), sym);
  endfunction

  function automatic void add_operand(int stars, bit num_ok);
    repeat (stars) append_sym(lrp_pkg::SYM_STAR);
    append_sym((num_ok && $urandom_range(0, 1) == 1) ? lrp_pkg::SYM_NUM : lrp_pkg::SYM_ID);
  endfunction

  // L = i | *(i|n), R = *^k (i|n); deep right sides can run the stack into overflow
  function automatic void build_sentence();
    int k;
    sentence_q.delete();
    if ($urandom_range(0, 1) == 1) begin
      k = $urandom_range(0, 1);
      add_operand(k, k > 0);
      append_sym(lrp_pkg::SYM_EQ);
      k = ($urandom_range(0, 11) == 0) ? $urandom_range(26, 34) : $urandom_range(0, 5);
      add_operand(k, 1'b1);
    end else begin
      add_operand($urandom_range(0, 1), 1'b1);
    end
    append_sym(lrp_pkg::SYM_END);
  endfunction

  task automatic test_terminals();
    calm = 1'b0;
    feed_symbol(lrp_pkg::SYM_END, 1'b0);
    feed_symbol(lrp_pkg::SYM_ID, 1'b0);
    feed_symbol(8'hFF, 1'b1);
    feed_symbol(8'h00, 1'b0);
    feed_symbol(lrp_pkg::SYM_NUM, 1'b1);
    feed_symbol(lrp_pkg::SYM_END, 1'b0);
    feed_symbol(lrp_pkg::SYM_STAR, 1'b1);
    feed_symbol(lrp_pkg::SYM_ID, 1'b0);
    feed_symbol(lrp_pkg::SYM_EQ, 1'b0);
    feed_symbol(lrp_pkg::SYM_STAR, 1'b0);
    feed_symbol(lrp_pkg::SYM_NUM, 1'b0);
    feed_symbol(lrp_pkg::SYM_END, 1'b0);
    feed_symbol(lrp_pkg::SYM_ID, 1'b1);
    feed_symbol(lrp_pkg::SYM_EQ, 1'b0);
    feed_symbol(lrp_pkg::SYM_STAR, 1'b1);
    feed_symbol(lrp_pkg::SYM_STAR, 1'b0);
    // restart in the middle of a parse
    feed_symbol(lrp_pkg::SYM_ID, 1'b1);
    feed_symbol(lrp_pkg::SYM_NUM, 1'b1);
    feed_symbol(lrp_pkg::SYM_END, 1'b0);
    feed_symbol(lrp_pkg::SYM_EQ, 1'b1);
  endtask

  task automatic test_sentences();
    while (fed_count < 420) begin
      calm = ($urandom_range(0, 6) == 0);
      build_sentence();
      feed_sentence();
    end
  endtask

  task automatic test_broken();
    int pos;
    while (fed_count < 560) begin
      calm = ($urandom_range(0, 6) == 0);
      build_sentence();
      pos = $urandom_range(0, sentence_q.size() - 1);
      case ($urandom_range(0, 3))
        0: sentence_q[pos] = pick_terminal();
        1: sentence_q[pos] = 8'($urandom_range(0, 255));
        2: if (sentence_q.size() > 1) sentence_q.delete(pos);
        default: sentence_q.delete(sentence_q.size() - 1);
      endcase
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 3)) append_sym(pick_terminal());
      feed_sentence();
    end
  endtask

  task automatic test_noise();
    logic [7:0] sym;
    while (fed_count < 700) begin
      calm = ($urandom_range(0, 15) == 0) ? ~calm : calm;
      sym = ($urandom_range(0, 1) == 1) ? pick_terminal() : 8'($urandom_range(0, 255));
      feed_symbol(sym, $urandom_range(0, 5) == 0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_r = {status_o, reject_cause_o, reductions_o, depth_o, top_state_o};
      if (step_results_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: status %0d", status_o);
      end else begin
        want_r = step_results_q.pop_front();
        if (seen_r !== want_r) begin
          errors++;
          if (errors <= 10)
            $display(
              "mismatch: status %0d/%0d cause %0d/%0d reds %0d/%0d depth %0d/%0d top %0d/%0d",
              want_r.status, seen_r.status, want_r.cause, seen_r.cause,
              want_r.reductions, seen_r.reductions, want_r.depth, seen_r.depth,
              want_r.top, seen_r.top);
        end
      end
      out_hold = draw_gap();
      out_stall_i <= (out_hold > 0);
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall_i <= (out_hold > 0);
    end
  end

  initial begin
    clear_parser();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_terminals();
    test_sentences();
    test_broken();
    test_noise();
    in_valid_i <= 1'b0;
    while (step_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("fed %0d items, %0d parsed, %0d ignored", fed_count, parsed_count,
             fed_count - parsed_count);
    $display("accepted %0d, rejected %0d, of them %0d on overflow", accept_count,
             reject_count, overflow_count);
    if (errors == 0 && step_results_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
hdl/lrp_pkg.sv
hdl/lrp_ram.sv
hdl/lrp_rom.sv
hdl/lr_parse_driver.sv
sim/tb.sv
